>>> hdl/sha1_pkg.sv
package sha1_pkg;

  localparam logic [31:0] Iv [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                     32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0] Kc [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                     32'hCA62C1D6};
  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

>>> hdl/sha1_wram.sv
module sha1_wram import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [31:0] wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem_q [16];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/sha1_digest_top.sv
// SHA-1 over a byte stream, one byte per input word, big-endian packing.
// A byte is taken each cycle until a 64-byte block is full. The input is then
// held off while one round unit compresses the block, one round per cycle. The
// block sits in a 16-entry memory that feeds rounds 0 to 15; the expanded
// schedule runs in a 16-word sliding window. On a last word the padding and
// the length are written into the memory, one word per cycle, and a message
// needs one or two padding blocks. The five digest words then leave, index 0
// first, one per cycle that the receiver takes.
module sha1_digest_top import sha1_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    S_IN, S_RND, S_PADW, S_OUT
  } state_e;

  state_e      state_q;
  logic [63:0] cnt_q;
  logic [31:0] acc_q;
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  rnd_q;
  logic        fin_q;
  logic        two_q;
  logic        pad_q;
  logic        sec_q;
  logic [3:0]  pw_q;
  logic [2:0]  oi_q;
  logic [31:0] w_hist_q [16];

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;

  sha1_wram u_wram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [5:0] pos;
  logic [31:0] acc_n;
  assign pos = cnt_q[5:0];
  always_comb begin
    acc_n = (pos[1:0] == 2'd0) ? 32'd0 : acc_q;
    acc_n[(3 - pos[1:0]) * 8 +: 8] = data_byte_i;
  end

  logic [31:0] wt, f, kk, tmp, sch;
  logic [1:0]  grp;
  always_comb begin
    sch = rotl(w_hist_q[13] ^ w_hist_q[8] ^ w_hist_q[2] ^ w_hist_q[0], 1);
    wt  = (rnd_q < 7'd16) ? rdata : sch;
    grp = (rnd_q < 7'd20) ? 2'd0 : (rnd_q < 7'd40) ? 2'd1 : (rnd_q < 7'd60) ? 2'd2 : 2'd3;
    unique case (grp)
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd2:    f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default: f = b_q ^ c_q ^ d_q;
    endcase
    kk  = Kc[grp];
    tmp = rotl(a_q, 5) + f + e_q + kk + wt;
  end

  logic [63:0] bits;
  logic [31:0] padw;
  logic        pad_we;
  assign bits = {cnt_q[60:0], 3'b000};
  always_comb begin
    padw   = 32'd0;
    pad_we = 1'b1;
    if (!sec_q && pw_q < pos[5:2]) begin
      pad_we = 1'b0;
    end else if (!sec_q && pw_q == pos[5:2]) begin
      for (int i = 0; i < 4; i++) begin
        if (2'(i) < pos[1:0]) padw[(3 - i) * 8 +: 8] = acc_q[(3 - i) * 8 +: 8];
        else if (2'(i) == pos[1:0]) padw[(3 - i) * 8 +: 8] = PadByte;
      end
    end else if (!two_q && pw_q == 4'd14) begin
      padw = bits[63:32];
    end else if (!two_q && pw_q == 4'd15) begin
      padw = bits[31:0];
    end
  end

  always_comb begin
    we = 1'b0; waddr = 4'd0; wdata = 32'd0; raddr = rnd_q[3:0];
    unique case (state_q)
      S_IN: begin
        we = valid_i && has_byte_i && pos[1:0] == 2'd3;
        waddr = pos[5:2]; wdata = acc_n;
        raddr = 4'd0;
      end
      S_PADW: begin
        we = pad_we; waddr = pw_q; wdata = padw; raddr = 4'd0;
      end
      S_RND: raddr = 4'(rnd_q + 7'd1);
      default: ;
    endcase
  end

  assign ready_o       = state_q == S_IN;
  assign valid_o       = state_q == S_OUT;
  assign digest_word_o = h_q[oi_q];
  assign word_index_o  = oi_q;
  assign last_word_o   = oi_q == 3'd4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      cnt_q   <= '0;
      for (int i = 0; i < 5; i++) h_q[i] <= Iv[i];
      for (int i = 0; i < 16; i++) w_hist_q[i] <= '0;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
      rnd_q <= '0; fin_q <= 1'b0; two_q <= 1'b0; pw_q <= '0; oi_q <= '0;
      pad_q <= 1'b0; sec_q <= 1'b0;
      acc_q <= '0;
    end else begin
      unique case (state_q)
        S_IN: if (valid_i) begin
          if (has_byte_i) begin
            acc_q <= acc_n;
            cnt_q <= cnt_q + 64'd1;
          end
          fin_q <= last_byte_i;
          if (has_byte_i && pos == 6'd63) begin
            state_q <= S_RND; rnd_q <= 7'd0; two_q <= 1'b0;
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
          end else if (last_byte_i) begin
            state_q <= S_PADW; pw_q <= 4'd0;
            two_q <= (has_byte_i ? pos + 6'd1 : pos) > 6'd55;
          end
        end
        S_PADW: begin
          pw_q  <= pw_q + 4'd1;
          pad_q <= 1'b1;
          if (pw_q == 4'd15) begin
            state_q <= S_RND; rnd_q <= 7'd0;
            a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
          end
        end
        S_RND: begin
          for (int i = 0; i < 15; i++) w_hist_q[i] <= w_hist_q[i + 1];
          w_hist_q[15] <= wt;
          e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 30); b_q <= a_q; a_q <= tmp;
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) begin
            h_q[0] <= h_q[0] + tmp;   h_q[1] <= h_q[1] + a_q;
            h_q[2] <= h_q[2] + rotl(b_q, 30);
            h_q[3] <= h_q[3] + c_q;   h_q[4] <= h_q[4] + d_q;
            if (!fin_q) state_q <= S_IN;
            else if (!pad_q || two_q) begin
              state_q <= S_PADW; pw_q <= 4'd0;
              sec_q <= two_q; two_q <= 1'b0;
            end else begin
              state_q <= S_OUT; oi_q <= 3'd0;
            end
          end
        end
        S_OUT: if (ready_i) begin
          if (oi_q == 3'd4) begin
            state_q <= S_IN; cnt_q <= '0; fin_q <= 1'b0; oi_q <= 3'd0;
            pad_q <= 1'b0; sec_q <= 1'b0;
            for (int i = 0; i < 5; i++) h_q[i] <= Iv[i];
          end else begin
            oi_q <= oi_q + 3'd1;
          end
        end
        default: state_q <= S_IN;
      endcase
    end
  end

endmodule

>>> hdl/sha1_digest_chk.sv
module sha1_digest_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        ready_o,
  input logic        valid_o,
  input logic        ready_i,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> word_index_o <= 3'd4) else $error("index range");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_word_o == (word_index_o == 3'd4))) else $error("last flag");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(valid_o && ready_o)) else $error("input taken during output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(word_index_o)) else $error("output dropped");

endmodule

bind sha1_digest_top sha1_digest_chk u_chk (.*);
